>>> hw/rtl/mmcp_pkg.sv
// ----------------------------------------------------------------------------
// mmcp_pkg
// shared widths, register codes and payload layout of the motor command packer
// ----------------------------------------------------------------------------
package mmcp_pkg;

  // input values and configuration registers
  localparam int VAL_W  = 32;          // signed Q15.16 command value
  localparam int CFG_W  = 31;          // unsigned Q15.16 bound register
  localparam int ADDR_W = 3;           // configuration register index
  localparam int BND_W  = VAL_W + 1;   // signed range bound, holds -limit
  localparam int SPAN_W = VAL_W;       // hi - lo, at most 2^32 - 2

  // code widths
  localparam int POS_CODE_W = 16;
  localparam int GEN_CODE_W = 12;
  localparam int DIV_STEPS  = POS_CODE_W;  // quotient bits produced per lane

  // per-lane pipeline: clamp stage, difference stage, one stage per quotient bit
  localparam int LANE_LAT = DIV_STEPS + 2;

  // beat widths
  localparam int NUM_FIELDS = 5;
  localparam int IN_W       = NUM_FIELDS * VAL_W;
  localparam int PAYLOAD_W  = 64;

  // result queue depth, must stay above the lane latency for full rate
  localparam int OUTQ_DEPTH = 32;

  // reset values of the bound registers
  localparam logic [CFG_W-1:0] RST_POS_LIMIT  = CFG_W'(6258688);
  localparam logic [CFG_W-1:0] RST_VEL_LIMIT  = CFG_W'(1966080);
  localparam logic [CFG_W-1:0] RST_TRQ_LIMIT  = CFG_W'(1179648);
  localparam logic [CFG_W-1:0] RST_STIFF_MIN  = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_STIFF_MAX  = CFG_W'(32768000);
  localparam logic [CFG_W-1:0] RST_DAMP_MIN   = CFG_W'(0);
  localparam logic [CFG_W-1:0] RST_DAMP_MAX   = CFG_W'(327680);

  // configuration register index
  typedef enum logic [ADDR_W-1:0] {
    REG_POS_LIMIT = 3'd0,
    REG_VEL_LIMIT = 3'd1,
    REG_TRQ_LIMIT = 3'd2,
    REG_STIFF_MIN = 3'd3,
    REG_STIFF_MAX = 3'd4,
    REG_DAMP_MIN  = 3'd5,
    REG_DAMP_MAX  = 3'd6
  } cfg_idx_t;

  // big-endian payload: position, velocity, stiffness, damping, torque
  function automatic logic [PAYLOAD_W-1:0] pack_payload(
    input logic [POS_CODE_W-1:0] pos_code,
    input logic [POS_CODE_W-1:0] vel_code,
    input logic [POS_CODE_W-1:0] kp_code,
    input logic [POS_CODE_W-1:0] kd_code,
    input logic [POS_CODE_W-1:0] trq_code
  );
    // 12-bit codes are the top bits of the 16-bit quotient
    return {pos_code,
            vel_code[POS_CODE_W-1 -: GEN_CODE_W],
            kp_code[POS_CODE_W-1 -: GEN_CODE_W],
            kd_code[POS_CODE_W-1 -: GEN_CODE_W],
            trq_code[POS_CODE_W-1 -: GEN_CODE_W]};
  endfunction

endpackage

>>> hw/rtl/mmcp_ram.sv
// ----------------------------------------------------------------------------
// mmcp_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mmcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/mmcp_lane.sv
// ----------------------------------------------------------------------------
// mmcp_lane
// clamp one value to [lo, hi] and scale it to a 16-bit code through a
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module mmcp_lane (
  input  logic                                  clk,
  input  logic signed [mmcp_pkg::VAL_W-1:0]     x,
  input  logic signed [mmcp_pkg::BND_W-1:0]     lo,
  input  logic signed [mmcp_pkg::BND_W-1:0]     hi,
  output logic [mmcp_pkg::POS_CODE_W-1:0]       code
);
  import mmcp_pkg::*;

  logic signed [BND_W-1:0]  x_ext;
  logic signed [BND_W-1:0]  x_clamp;
  logic signed [BND_W-1:0]  span_full;
  logic signed [BND_W-1:0]  diff_full;

  logic signed [BND_W-1:0]  xc_r;
  logic signed [BND_W-1:0]  lo_r;
  logic [SPAN_W-1:0]        span1_r;
  logic                     empty1_r;

  logic [SPAN_W-1:0]        diff_r;
  logic [SPAN_W-1:0]        span2_r;
  logic                     empty2_r;

  // divider stage registers, one entry per quotient bit
  logic [SPAN_W-1:0]        rem_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0]     quo_r   [DIV_STEPS];
  logic [SPAN_W-1:0]        dspan_r [DIV_STEPS];
  logic                     dempty_r[DIV_STEPS];
  logic                     dsat_r  [DIV_STEPS];

  // clamp and span, compares run side by side
  always_comb begin
    x_ext     = {x[VAL_W-1], x};
    span_full = hi - lo;
    if (x_ext < lo) begin
      x_clamp = lo;
    end else if (x_ext > hi) begin
      x_clamp = hi;
    end else begin
      x_clamp = x_ext;
    end
  end

  always_ff @(posedge clk) begin
    xc_r     <= x_clamp;
    lo_r     <= lo;
    span1_r  <= span_full[SPAN_W-1:0];
    empty1_r <= (hi <= lo);
  end

  // offset from the low bound, 0 .. span
  assign diff_full = xc_r - lo_r;

  always_ff @(posedge clk) begin
    diff_r   <= diff_full[SPAN_W-1:0];
    span2_r  <= span1_r;
    empty2_r <= empty1_r;
  end

  // restoring division of diff * 2^16 by span
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [SPAN_W-1:0]    r_in;
    logic [SPAN_W-1:0]    sp_in;
    logic [DIV_STEPS-1:0] q_in;
    logic                 e_in;
    logic                 sat_in;
    logic [SPAN_W:0]      r_dbl;
    logic [SPAN_W:0]      r_sub;
    logic                 ge;

    if (s == 0) begin : g_first
      assign r_in   = diff_r;
      assign sp_in  = span2_r;
      assign q_in   = '0;
      assign e_in   = empty2_r;
      // value at the top of its range gives the full-scale code
      assign sat_in = (diff_r >= span2_r);
    end else begin : g_next
      assign r_in   = rem_r[s-1];
      assign sp_in  = dspan_r[s-1];
      assign q_in   = quo_r[s-1];
      assign e_in   = dempty_r[s-1];
      assign sat_in = dsat_r[s-1];
    end

    assign r_dbl = {r_in, 1'b0};
    assign r_sub = r_dbl - {1'b0, sp_in};
    assign ge    = (r_dbl >= {1'b0, sp_in});

    always_ff @(posedge clk) begin
      rem_r[s]    <= ge ? r_sub[SPAN_W-1:0] : r_dbl[SPAN_W-1:0];
      quo_r[s]    <= {q_in[DIV_STEPS-2:0], ge};
      dspan_r[s]  <= sp_in;
      dempty_r[s] <= e_in;
      dsat_r[s]   <= sat_in;
    end
  end

  // empty range gives zero, top of range saturates
  always_comb begin
    if (dempty_r[DIV_STEPS-1]) begin
      code = '0;
    end else if (dsat_r[DIV_STEPS-1]) begin
      code = '1;
    end else begin
      code = quo_r[DIV_STEPS-1];
    end
  end

endmodule

>>> hw/rtl/mmcp_outq.sv
// ----------------------------------------------------------------------------
// mmcp_outq
// result queue in ram; the ram read register drives the output beat
// ----------------------------------------------------------------------------
module mmcp_outq #(
  parameter int DEPTH = mmcp_pkg::OUTQ_DEPTH,
  parameter int WIDTH = mmcp_pkg::PAYLOAD_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [WIDTH-1:0]           out_tdata,
  output logic                       pop,
  output logic [$clog2(DEPTH+1)-1:0] cnt
);
  import mmcp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          vld_r, vld_nxt;

  mmcp_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr_r),
    .wr_data (push_data),
    .rd_en   (pop),
    .rd_addr (rd_ptr_r),
    .rd_data (out_tdata)
  );

  // read the next entry when the output beat is free or leaving
  assign pop = (cnt_r != '0) && (!vld_r || out_tready);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
    if (pop) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      vld_r    <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      vld_r    <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign cnt        = cnt_r;

endmodule

>>> hw/rtl/mit_mode_command_packer.sv
// ----------------------------------------------------------------------------
// mit_mode_command_packer
// clamps and scales one motor command to fixed-width codes and packs them
// into an 8-byte big-endian payload
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// in_       in   tdata: target_position, target_velocity, stiffness_gain,
//                damping_gain, feedforward_torque (32 bits each)
// out_      out  tdata: frame_payload (64 bits, byte 0 in the top bits)
// cfg_      in   wr_en, addr (register index), wr_data (31 bits)
//
// one command per cycle while out_ is not stalled; a payload passes the 18
// lane stages, a queue write and one ram read before it shows on out_.
// the five lanes are divider pipelines that never stall; a result queue of
// FIFO_DEPTH entries in ram absorbs output stalls, and in_tready drops once
// commands in flight plus queued results reach FIFO_DEPTH.
// reset is synchronous: queue and pipeline empty, bounds at their defaults.
// ----------------------------------------------------------------------------
module mit_mode_command_packer #(
  parameter int FIFO_DEPTH = mmcp_pkg::OUTQ_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] target_position, [63:32] target_velocity, [95:64] stiffness_gain,
  // [127:96] damping_gain, [159:128] feedforward_torque
  input  logic [mmcp_pkg::IN_W-1:0]     in_tdata,
  // payload beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [63:0] frame_payload
  output logic [mmcp_pkg::PAYLOAD_W-1:0] out_tdata,
  // configuration writes
  input  logic                          cfg_wr_en,
  input  logic [mmcp_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [mmcp_pkg::CFG_W-1:0]    cfg_wr_data
);
  import mmcp_pkg::*;

  localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

  logic [CFG_W-1:0] pos_limit_r, vel_limit_r, trq_limit_r;
  logic [CFG_W-1:0] stiff_min_r, stiff_max_r, damp_min_r, damp_max_r;

  logic                   in_fire;
  logic [LANE_LAT-1:0]    vld_r;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic                   q_pop;
  logic [OCC_W-1:0]       q_cnt;
  logic                   q_push;
  logic [PAYLOAD_W-1:0]   payload;

  logic signed [BND_W-1:0] lo   [NUM_FIELDS];
  logic signed [BND_W-1:0] hi   [NUM_FIELDS];
  logic [POS_CODE_W-1:0]   codes[NUM_FIELDS];

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_limit_r <= RST_POS_LIMIT;
      vel_limit_r <= RST_VEL_LIMIT;
      trq_limit_r <= RST_TRQ_LIMIT;
      stiff_min_r <= RST_STIFF_MIN;
      stiff_max_r <= RST_STIFF_MAX;
      damp_min_r  <= RST_DAMP_MIN;
      damp_max_r  <= RST_DAMP_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_POS_LIMIT: pos_limit_r <= cfg_wr_data;
        REG_VEL_LIMIT: vel_limit_r <= cfg_wr_data;
        REG_TRQ_LIMIT: trq_limit_r <= cfg_wr_data;
        REG_STIFF_MIN: stiff_min_r <= cfg_wr_data;
        REG_STIFF_MAX: stiff_max_r <= cfg_wr_data;
        REG_DAMP_MIN:  damp_min_r  <= cfg_wr_data;
        REG_DAMP_MAX:  damp_max_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // signed range bounds per lane
  always_comb begin
    hi[0] = $signed({2'b00, pos_limit_r});
    lo[0] = -hi[0];
    hi[1] = $signed({2'b00, vel_limit_r});
    lo[1] = -hi[1];
    lo[2] = $signed({2'b00, stiff_min_r});
    hi[2] = $signed({2'b00, stiff_max_r});
    lo[3] = $signed({2'b00, damp_min_r});
    hi[3] = $signed({2'b00, damp_max_r});
    hi[4] = $signed({2'b00, trq_limit_r});
    lo[4] = -hi[4];
  end

  // one scaling lane per field
  for (genvar f = 0; f < NUM_FIELDS; f++) begin : g_lane
    mmcp_lane u_lane (
      .clk  (clk),
      .x    ($signed(in_tdata[f*VAL_W +: VAL_W])),
      .lo   (lo[f]),
      .hi   (hi[f]),
      .code (codes[f])
    );
  end

  // credit: commands in flight plus queued results
  assign in_tready = (occ_r < OCC_W'(FIFO_DEPTH));
  assign in_fire   = in_tvalid && in_tready;
  assign occ_nxt   = occ_r + OCC_W'(in_fire) - OCC_W'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      occ_r <= '0;
    end else begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_fire};
      occ_r <= occ_nxt;
    end
  end

  // pack codes as they leave the lanes
  assign q_push  = vld_r[LANE_LAT-1];
  assign payload = pack_payload(codes[0], codes[1], codes[2], codes[3], codes[4]);

  mmcp_outq #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (PAYLOAD_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (payload),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pop        (q_pop),
    .cnt        (q_cnt)
  );

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_cnt < OCC_W'(FIFO_DEPTH)))
    else $error("result written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_cnt != '0))
    else $error("read from an empty queue");

  a_cnt_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= occ_r)
    else $error("queue holds more results than credited commands");

endmodule

>>> dv/mmcp_payload_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmcp_payload_checker
// watches the command, payload and bound-write ports of the command packer,
// keeps its own copy of the range bounds, predicts each payload from the
// accepted command and compares it with the payload beats in order
// ----------------------------------------------------------------------------
module mmcp_payload_checker
  import mmcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [PAYLOAD_W-1:0] out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [ADDR_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  output int                   errors,
  output int                   outstanding,
  output int                   checked
);

  // command beat, first field in the low bits
  typedef struct packed {
    logic signed [VAL_W-1:0] trq;
    logic signed [VAL_W-1:0] kd;
    logic signed [VAL_W-1:0] kp;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] pos;
  } command_t;

  // shadow copy of the range bounds
  logic [CFG_W-1:0] pos_lim, vel_lim, trq_lim;
  logic [CFG_W-1:0] kp_min, kp_max, kd_min, kd_max;

  // payloads predicted but not yet seen
  logic [PAYLOAD_W-1:0] payload_q[$];
  logic [PAYLOAD_W-1:0] want;

  // clamp to [lo, hi] and scale to a code of the given width
  function automatic logic [POS_CODE_W-1:0] scale_to_code(longint x, longint lo,
                                                          longint hi, int bits);
    longint unsigned diff, span, code, top;
    top = (64'd1 << bits) - 64'd1;
    if (hi <= lo) return '0;
    if (x < lo) x = lo;
    else if (x > hi) x = hi;
    diff = longint'(x - lo);
    span = longint'(hi - lo);
    code = (diff << bits) / span;
    // top of the range would wrap, pin it to the largest code
    if (code > top) code = top;
    return code[POS_CODE_W-1:0];
  endfunction

  function automatic logic [PAYLOAD_W-1:0] pack_command(command_t c);
    longint pl, vl, tl;
    logic [POS_CODE_W-1:0] p, v, kp, kd, t;
    pl = longint'({33'd0, pos_lim});
    vl = longint'({33'd0, vel_lim});
    tl = longint'({33'd0, trq_lim});
    p  = scale_to_code(longint'(c.pos), -pl, pl, POS_CODE_W);
    v  = scale_to_code(longint'(c.vel), -vl, vl, GEN_CODE_W);
    kp = scale_to_code(longint'(c.kp), longint'({33'd0, kp_min}),
                       longint'({33'd0, kp_max}), GEN_CODE_W);
    kd = scale_to_code(longint'(c.kd), longint'({33'd0, kd_min}),
                       longint'({33'd0, kd_max}), GEN_CODE_W);
    t  = scale_to_code(longint'(c.trq), -tl, tl, GEN_CODE_W);
    return {p, v[GEN_CODE_W-1:0], kp[GEN_CODE_W-1:0], kd[GEN_CODE_W-1:0],
            t[GEN_CODE_W-1:0]};
  endfunction

  // track bound writes, predict on command beats, compare on payload beats
  always @(posedge clk) begin
    if (!rst_n) begin
      pos_lim <= RST_POS_LIMIT;
      vel_lim <= RST_VEL_LIMIT;
      trq_lim <= RST_TRQ_LIMIT;
      kp_min  <= RST_STIFF_MIN;
      kp_max  <= RST_STIFF_MAX;
      kd_min  <= RST_DAMP_MIN;
      kd_max  <= RST_DAMP_MAX;
      payload_q.delete();
      outstanding <= 0;
      errors      <= 0;
      checked     <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_POS_LIMIT: pos_lim <= cfg_wr_data;
          REG_VEL_LIMIT: vel_lim <= cfg_wr_data;
          REG_TRQ_LIMIT: trq_lim <= cfg_wr_data;
          REG_STIFF_MIN: kp_min  <= cfg_wr_data;
          REG_STIFF_MAX: kp_max  <= cfg_wr_data;
          REG_DAMP_MIN:  kd_min  <= cfg_wr_data;
          REG_DAMP_MAX:  kd_max  <= cfg_wr_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        payload_q.push_back(pack_command(command_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        if (payload_q.size() == 0) begin
          $display("%0t: payload beat with none expected, actual %h", $time, out_tdata);
          errors <= errors + 1;
        end else begin
          want = payload_q.pop_front();
          checked <= checked + 1;
          if (out_tdata !== want) begin
            $display("%0t: frame_payload mismatch, expected %h actual %h",
                     $time, want, out_tdata);
            errors <= errors + 1;
          end
        end
      end
      outstanding <= payload_q.size();
    end
  end

endmodule

>>> dv/tb_mit_mode_command_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mit_mode_command_packer
// drives motor commands into the packer under several bound settings, with
// random gaps on the command side and random stalls on the payload side;
// the checker predicts every payload and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_mit_mode_command_packer;
  import mmcp_pkg::*;

  localparam int PIPE_LAT    = 19;     // base of the quiet wait at the end of drain
  localparam int GAP_MAX     = 17;
  localparam int QUIET_LIMIT = 2000;   // cycles with no beat before giving up
  localparam logic [ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [CFG_W-1:0]  CFG_FULL   = '1;
  localparam logic [VAL_W-1:0]  Q_MIN      = 32'h8000_0000;
  localparam logic [VAL_W-1:0]  Q_MAX      = 32'h7FFF_FFFF;
  localparam longint Q_LO = -64'sd2147483648;
  localparam longint Q_HI = 64'sd2147483647;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata    = '0;
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [PAYLOAD_W-1:0] out_tdata;
  logic                 cfg_wr_en   = 1'b0;
  logic [ADDR_W-1:0]    cfg_addr    = '0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;

  int errors, outstanding, checked;
  int sent     = 0;
  int settings = 1;
  int quiet    = 0;
  bit burst    = 1'b0;

  // bound values as last written, and the field ranges they give
  logic [CFG_W-1:0] cfg_val [7];
  longint fld_lo [5];
  longint fld_hi [5];

  mit_mode_command_packer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  mmcp_payload_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // saturate to the signed Q15.16 field range
  function automatic logic [VAL_W-1:0] to_q(longint v);
    if (v > Q_HI) return Q_MAX;
    if (v < Q_LO) return Q_MIN;
    return v[VAL_W-1:0];
  endfunction

  function automatic void refresh_bounds();
    fld_lo[0] = -longint'({33'd0, cfg_val[REG_POS_LIMIT]});
    fld_hi[0] =  longint'({33'd0, cfg_val[REG_POS_LIMIT]});
    fld_lo[1] = -longint'({33'd0, cfg_val[REG_VEL_LIMIT]});
    fld_hi[1] =  longint'({33'd0, cfg_val[REG_VEL_LIMIT]});
    fld_lo[2] =  longint'({33'd0, cfg_val[REG_STIFF_MIN]});
    fld_hi[2] =  longint'({33'd0, cfg_val[REG_STIFF_MAX]});
    fld_lo[3] =  longint'({33'd0, cfg_val[REG_DAMP_MIN]});
    fld_hi[3] =  longint'({33'd0, cfg_val[REG_DAMP_MAX]});
    fld_lo[4] = -longint'({33'd0, cfg_val[REG_TRQ_LIMIT]});
    fld_hi[4] =  longint'({33'd0, cfg_val[REG_TRQ_LIMIT]});
  endfunction

  // directed value of one field: bounds, midpoint, one step in and out
  function automatic logic [VAL_W-1:0] pick(int kind, int f);
    longint lo, hi;
    lo = fld_lo[f];
    hi = fld_hi[f];
    case (kind)
      0:       return to_q(lo);
      1:       return to_q(hi);
      2:       return to_q((lo + hi) / 2);
      3:       return to_q(lo + 1);
      4:       return to_q(hi - 1);
      5:       return to_q(lo - 1);
      default: return to_q(hi + 1);
    endcase
  endfunction

  // random field value, mostly around its range, some anywhere
  function automatic logic [VAL_W-1:0] rand_field(int f);
    longint lo, hi, span, a, b, v;
    lo = (fld_lo[f] < fld_hi[f]) ? fld_lo[f] : fld_hi[f];
    hi = (fld_lo[f] < fld_hi[f]) ? fld_hi[f] : fld_lo[f];
    span = (hi > lo) ? hi - lo : 64;
    case ($urandom_range(0, 9))
      0, 1: v = longint'(int'($urandom));
      2:    v = fld_lo[f];
      3:    v = fld_hi[f];
      4:    v = fld_lo[f] + longint'($urandom_range(0, 2)) - 1;
      5:    v = fld_hi[f] + longint'($urandom_range(0, 2)) - 1;
      default: begin
        a = lo - span / 8;
        b = hi + span / 8;
        v = a + longint'({$urandom, $urandom} % longint'(b - a + 1));
      end
    endcase
    return to_q(v);
  endfunction

  function automatic logic [CFG_W-1:0] rand_bound();
    case ($urandom_range(0, 3))
      0:       return CFG_W'($urandom_range(1, 255));
      1:       return CFG_W'($urandom_range(32'h1_0000, 32'h100_0000));
      2:       return CFG_W'($urandom);
      default: return CFG_FULL - CFG_W'($urandom_range(0, 3));
    endcase
  endfunction

  // one command beat, after a random gap unless in a burst stretch
  task automatic send_cmd(input logic [IN_W-1:0] cmd);
    int gap;
    gap = burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmd;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_kind(input int k, input bit mix);
    logic [IN_W-1:0] cmd;
    for (int f = 0; f < NUM_FIELDS; f++)
      cmd[f*VAL_W +: VAL_W] = pick(mix ? (k + f) % 7 : k, f);
    send_cmd(cmd);
  endtask

  task automatic run_random(input int n);
    logic [IN_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      // switch between idling and back-to-back stretches
      if (i % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      for (int f = 0; f < NUM_FIELDS; f++)
        cmd[f*VAL_W +: VAL_W] = rand_field(f);
      send_cmd(cmd);
    end
    burst = 1'b0;
  endtask

  // stop sending, let every payload drain, then let the pipe go quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // write all bounds in register order, optionally poke the unused index
  task automatic cfg_apply(input bit poke_unused);
    cfg_idx_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_wr_en   <= 1'b1;
      cfg_addr    <= r;
      cfg_wr_data <= cfg_val[r];
      @(posedge clk);
      r = r.next();
    end
    if (poke_unused) begin
      cfg_addr    <= REG_UNUSED;
      cfg_wr_data <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    refresh_bounds();
    settings++;
  endtask

  task automatic rand_config();
    cfg_val[REG_POS_LIMIT] = rand_bound();
    cfg_val[REG_VEL_LIMIT] = rand_bound();
    cfg_val[REG_TRQ_LIMIT] = rand_bound();
    cfg_val[REG_STIFF_MAX] = rand_bound();
    cfg_val[REG_DAMP_MAX]  = rand_bound();
    // mostly a proper range, now and then an arbitrary pair
    if ($urandom_range(0, 7) == 0) cfg_val[REG_STIFF_MIN] = CFG_W'($urandom);
    else cfg_val[REG_STIFF_MIN] = CFG_W'($urandom_range(0, 32'(cfg_val[REG_STIFF_MAX]) - 1));
    if ($urandom_range(0, 7) == 0) cfg_val[REG_DAMP_MIN] = CFG_W'($urandom);
    else cfg_val[REG_DAMP_MIN] = CFG_W'($urandom_range(0, 32'(cfg_val[REG_DAMP_MAX]) - 1));
    cfg_apply($urandom_range(0, 1));
  endtask

  // output side: random stall before each payload beat unless in a burst stretch
  initial begin : payload_side
    int stall;
    forever begin
      stall = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: timeout, no beat for %0d cycles, %0d payloads outstanding",
                 $time, QUIET_LIMIT, outstanding);
        $display("** mit_mode_command_packer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    cfg_val[REG_POS_LIMIT] = RST_POS_LIMIT;
    cfg_val[REG_VEL_LIMIT] = RST_VEL_LIMIT;
    cfg_val[REG_TRQ_LIMIT] = RST_TRQ_LIMIT;
    cfg_val[REG_STIFF_MIN] = RST_STIFF_MIN;
    cfg_val[REG_STIFF_MAX] = RST_STIFF_MAX;
    cfg_val[REG_DAMP_MIN]  = RST_DAMP_MIN;
    cfg_val[REG_DAMP_MAX]  = RST_DAMP_MAX;
    refresh_bounds();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bounds: bounds, midpoints, one step in and out, full-scale and pattern words, then random
    for (int k = 0; k < 7; k++) send_kind(k, 1'b0);
    for (int k = 0; k < 7; k++) send_kind(k, 1'b1);
    send_cmd({NUM_FIELDS{Q_MIN}});
    send_cmd({NUM_FIELDS{Q_MAX}});
    send_cmd('0);
    send_cmd('1);
    send_cmd({NUM_FIELDS{32'h5555_AAAA}});
    run_random(90);
    drain();

    // widest ranges the registers hold
    cfg_val[REG_POS_LIMIT] = CFG_FULL;
    cfg_val[REG_VEL_LIMIT] = CFG_FULL;
    cfg_val[REG_TRQ_LIMIT] = CFG_FULL;
    cfg_val[REG_STIFF_MIN] = '0;
    cfg_val[REG_STIFF_MAX] = CFG_FULL;
    cfg_val[REG_DAMP_MIN]  = '0;
    cfg_val[REG_DAMP_MAX]  = CFG_FULL;
    cfg_apply(1'b0);
    run_random(90);
    drain();

    // narrowest ranges, a span of one or two lsb
    cfg_val[REG_POS_LIMIT] = CFG_W'(1);
    cfg_val[REG_VEL_LIMIT] = CFG_W'(1);
    cfg_val[REG_TRQ_LIMIT] = CFG_W'(1);
    cfg_val[REG_STIFF_MIN] = '0;
    cfg_val[REG_STIFF_MAX] = CFG_W'(1);
    cfg_val[REG_DAMP_MIN]  = CFG_W'(5);
    cfg_val[REG_DAMP_MAX]  = CFG_W'(6);
    cfg_apply(1'b0);
    run_random(80);
    drain();

    // empty and inverted ranges, plus a write to the unused index
    cfg_val[REG_POS_LIMIT] = '0;
    cfg_val[REG_VEL_LIMIT] = CFG_W'(1);
    cfg_val[REG_TRQ_LIMIT] = CFG_FULL;
    cfg_val[REG_STIFF_MIN] = CFG_W'(100 << 16);
    cfg_val[REG_STIFF_MAX] = CFG_W'(100 << 16);
    cfg_val[REG_DAMP_MIN]  = CFG_W'(9 << 16);
    cfg_val[REG_DAMP_MAX]  = CFG_W'(3 << 16);
    cfg_apply(1'b1);
    run_random(80);
    drain();

    // random bound settings
    repeat (2) begin
      rand_config();
      run_random(90);
      drain();
    end

    $display("run summary: %0d commands over %0d bound settings, %0d payloads checked",
             sent, settings, checked);
    $display("bounds used: reset, full scale, one-lsb spans, empty and inverted, random");
    if (outstanding != 0)
      $display("%0t: %0d expected payloads never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0)
      $display("** mit_mode_command_packer: PASSED **");
    else
      $display("** mit_mode_command_packer: FAILED **");
    $finish;
  end

endmodule
